### hdl/tmhp_pkg.sv
package tmhp_pkg;

  localparam int ROUTE_BYTES_DEF  = 128;
  localparam int BODY_BYTES_DEF   = 512;
  localparam int NAME_BYTES_DEF   = 64;
  localparam int VALUE_BYTES_DEF  = 128;
  localparam int HEADER_SLOTS_DEF = 16;

  // result queue between the parser and the output side
  localparam int QDEPTH = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef enum logic [2:0] {
    KIND_DROP  = 3'd0,
    KIND_ROUTE = 3'd1,
    KIND_NAME  = 3'd2,
    KIND_VALUE = 3'd3,
    KIND_BODY  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [3:0]  header_slot;
    logic [8:0]  field_offset;
    logic        run_last;
    logic        message_end;
    logic        prefix_ok;
    logic        blank_line_seen;
    logic [4:0]  header_count;
  } result_t;

endpackage

### hdl/tmhp_front.sv
module tmhp_front
  import tmhp_pkg::*;
#(
  parameter int ROUTE_BYTES  = ROUTE_BYTES_DEF,
  parameter int BODY_BYTES   = BODY_BYTES_DEF,
  parameter int NAME_BYTES   = NAME_BYTES_DEF,
  parameter int VALUE_BYTES  = VALUE_BYTES_DEF,
  parameter int HEADER_SLOTS = HEADER_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_message_i,
  output result_t    res_o [2],
  output logic [1:0] res_cnt_o
);

  localparam int LineKeep = NAME_BYTES + VALUE_BYTES + 3;
  localparam int RW = $clog2(ROUTE_BYTES);
  localparam int BW = $clog2(BODY_BYTES);
  localparam int NW = $clog2(NAME_BYTES);
  localparam int VW = $clog2(VALUE_BYTES);
  localparam int LW = $clog2(LineKeep + 1);
  localparam int HW = $clog2(HEADER_SLOTS + 1);

  typedef enum logic [3:0] {
    PH_P0, PH_P1, PH_P2, PH_ROUTE, PH_ROUTE_REST, PH_LINE_START, PH_HEADER,
    PH_SKIP, PH_BODY, PH_TERM_NOBODY, PH_TERM_BODY, PH_BAD
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [LW-1:0]   line_q, line_d;
  logic [NW-1:0]   name_q, name_d;
  logic [VW-1:0]   val_q, val_d;
  logic [RW-1:0]   route_q, route_d;
  logic [BW-1:0]   body_q, body_d;
  logic [HW-1:0]   hdr_q, hdr_d;
  logic            held_q, held_d;
  logic            sep_q, sep_d;

  always_comb begin
    logic            do_hdr;
    logic [LW-1:0]   h_pos;
    logic [NW-1:0]   h_name;
    logic [NW-1:0]   name_after;
    logic [VW-1:0]   h_val;
    logic            h_held;
    logic            h_sep;
    logic [HW-1:0]   h_slot;
    logic            rel_v;
    logic            cur_v;
    result_t         rel_r;
    result_t         cur_r;
    logic [7:0]      c;

    c       = in_byte_i;
    phase_d = phase_q;
    line_d  = line_q;
    name_d  = name_q;
    val_d   = val_q;
    route_d = route_q;
    body_d  = body_q;
    hdr_d   = hdr_q;
    held_d  = held_q;
    sep_d   = sep_q;
    do_hdr  = 1'b0;
    h_pos   = line_q;
    h_name  = name_q;
    h_val   = val_q;
    h_held  = held_q;
    h_sep   = sep_q;
    h_slot  = (hdr_q == '0) ? '0 : hdr_q - 1'b1;
    name_after = name_q;
    rel_v   = 1'b0;
    cur_v   = 1'b1;
    rel_r   = '0;
    cur_r   = '0;

    case (phase_q)
      PH_P0: phase_d = (c == CH_P)  ? PH_P1 : PH_BAD;
      PH_P1: phase_d = (c == CH_T)  ? PH_P2 : PH_BAD;
      PH_P2: phase_d = (c == CH_SP) ? PH_ROUTE : PH_BAD;
      PH_ROUTE: begin
        if (c == CH_SP) begin
          phase_d = PH_ROUTE_REST;
        end else if (c == CH_LF) begin
          phase_d = PH_LINE_START;
          line_d = '0; name_d = '0; val_d = '0; held_d = 1'b0; sep_d = 1'b0;
        end else if (c == CH_NUL) begin
          phase_d = PH_TERM_NOBODY;
        end else if (route_q < RW'(ROUTE_BYTES - 1)) begin
          cur_r.kind = KIND_ROUTE;
          cur_r.out_byte = c;
          cur_r.field_offset = 9'(route_q);
          route_d = route_q + 1'b1;
        end
      end
      PH_ROUTE_REST, PH_SKIP: begin
        if (c == CH_LF) begin
          phase_d = PH_LINE_START;
          line_d = '0; name_d = '0; val_d = '0; held_d = 1'b0; sep_d = 1'b0;
        end else if (c == CH_NUL) begin
          phase_d = PH_TERM_NOBODY;
        end
      end
      PH_LINE_START: begin
        if (c == CH_LF) begin
          phase_d = PH_BODY;
        end else if (c == CH_NUL) begin
          phase_d = PH_TERM_NOBODY;
        end else if (hdr_q < HW'(HEADER_SLOTS)) begin
          hdr_d   = hdr_q + 1'b1;
          phase_d = PH_HEADER;
          do_hdr  = 1'b1;
          h_pos = '0; h_name = '0; h_val = '0; h_held = 1'b0; h_sep = 1'b0;
          h_slot = hdr_q;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_HEADER: do_hdr = 1'b1;
      PH_BODY: begin
        if (c == CH_NUL) begin
          phase_d = PH_TERM_BODY;
        end else if (body_q < BW'(BODY_BYTES - 1)) begin
          cur_r.kind = KIND_BODY;
          cur_r.out_byte = c;
          cur_r.field_offset = 9'(body_q);
          body_d = body_q + 1'b1;
        end
      end
      default: ;
    endcase

    if (do_hdr) begin
      line_d = h_pos;
      name_d = h_name;
      val_d  = h_val;
      held_d = h_held;
      sep_d  = h_sep;
      // a held colon goes out as a name byte, if the name has room, unless this byte completes ": "
      name_after = h_name;
      rel_v = h_held && (c != CH_SP);
      if (rel_v && h_name < NW'(NAME_BYTES - 1)) begin
        rel_r.kind = KIND_NAME;
        rel_r.out_byte = CH_COLON;
        rel_r.header_slot = 4'(h_slot);
        rel_r.field_offset = 9'(h_name);
        name_after = h_name + 1'b1;
      end
      if (c == CH_LF) begin
        phase_d = PH_LINE_START;
        line_d = '0; name_d = '0; val_d = '0; held_d = 1'b0; sep_d = 1'b0;
      end else if (c == CH_NUL) begin
        phase_d = PH_TERM_NOBODY;
        held_d = 1'b0;
        name_d = name_after;
      end else begin
        line_d = (h_pos < LW'(LineKeep)) ? h_pos + 1'b1 : LW'(LineKeep);
        if (h_sep) begin
          if (h_pos < LW'(LineKeep) && h_val < VW'(VALUE_BYTES - 1)) begin
            cur_r.kind = KIND_VALUE;
            cur_r.out_byte = c;
            cur_r.header_slot = 4'(h_slot);
            cur_r.field_offset = 9'(h_val);
            val_d = h_val + 1'b1;
          end
        end else if (h_held && c == CH_SP) begin
          held_d = 1'b0;
          sep_d  = 1'b1;
        end else begin
          held_d = 1'b0;
          name_d = name_after;
          if (c == CH_COLON && h_pos < LW'(LineKeep - 1) && !end_of_message_i) begin
            held_d = 1'b1;
            cur_v  = 1'b0;
          end else if (h_pos < LW'(LineKeep) && name_after < NW'(NAME_BYTES - 1)) begin
            cur_r.kind = KIND_NAME;
            cur_r.out_byte = c;
            cur_r.header_slot = 4'(h_slot);
            cur_r.field_offset = 9'(name_after);
            name_d = name_after + 1'b1;
          end
        end
      end
    end

    if (rel_v) begin
      res_o[0] = rel_r;
      res_o[1] = cur_r;
    end else begin
      res_o[0] = cur_r;
      res_o[1] = '0;
    end
    res_cnt_o = {1'b0, rel_v} + {1'b0, cur_v};

    if (res_cnt_o != 2'd0) begin
      res_o[res_cnt_o[1]].run_last = 1'b1;
      if (end_of_message_i) begin
        res_o[res_cnt_o[1]].message_end = 1'b1;
        res_o[res_cnt_o[1]].prefix_ok = !(phase_d == PH_P0 || phase_d == PH_P1 ||
                                          phase_d == PH_P2 || phase_d == PH_BAD);
        res_o[res_cnt_o[1]].blank_line_seen = (phase_d == PH_BODY) ||
                                              (phase_d == PH_TERM_BODY);
        res_o[res_cnt_o[1]].header_count = 5'(hdr_d);
      end
    end
    if (!in_valid_i) begin
      res_cnt_o = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_P0;
      line_q  <= '0;
      name_q  <= '0;
      val_q   <= '0;
      route_q <= '0;
      body_q  <= '0;
      hdr_q   <= '0;
      held_q  <= 1'b0;
      sep_q   <= 1'b0;
    end else if (in_valid_i) begin
      if (end_of_message_i) begin
        phase_q <= PH_P0;
        line_q  <= '0;
        name_q  <= '0;
        val_q   <= '0;
        route_q <= '0;
        body_q  <= '0;
        hdr_q   <= '0;
        held_q  <= 1'b0;
        sep_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        line_q  <= line_d;
        name_q  <= name_d;
        val_q   <= val_d;
        route_q <= route_d;
        body_q  <= body_d;
        hdr_q   <= hdr_d;
        held_q  <= held_d;
        sep_q   <= sep_d;
      end
    end
  end

endmodule

### hdl/tmhp_queue.sv
module tmhp_queue
  import tmhp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] wr_cnt_i,
  input  result_t    wr_data_i [2],
  input  logic       pop_i,
  output result_t    head_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  result_t        mem_q [QDEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_pop;
  logic [PW-1:0]  wr_next;

  assign empty_o = (cnt_q == '0);
  // room is kept for the two results one transaction can produce
  assign full_o  = (cnt_q > CW'(QDEPTH - 2));
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];
  assign wr_next = wr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wr_q] <= wr_data_i[0];
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wr_next] <= wr_data_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PW'(wr_cnt_i);
      rd_q  <= rd_q + PW'(do_pop);
      cnt_q <= cnt_q + CW'(wr_cnt_i) - CW'(do_pop);
    end
  end

endmodule

### hdl/text_message_header_parser_unit.sv
// Throughput: one byte per cycle while full is low; a byte that releases a held
// colon yields two results (one if it is itself a held colon), which leave one per
// cycle while pop is high from the four-entry result queue. full is high while
// fewer than two queue entries are free. Reset (rst_ni low, asynchronous) empties
// the queue and returns the parser to the start of a message.
module text_message_header_parser_unit
  import tmhp_pkg::*;
#(
  parameter int ROUTE_BYTES  = ROUTE_BYTES_DEF,
  parameter int BODY_BYTES   = BODY_BYTES_DEF,
  parameter int NAME_BYTES   = NAME_BYTES_DEF,
  parameter int VALUE_BYTES  = VALUE_BYTES_DEF,
  parameter int HEADER_SLOTS = HEADER_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_message_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [3:0] header_slot_o,
  output logic [8:0] field_offset_o,
  output logic       run_last_o,
  output logic       message_end_o,
  output logic       prefix_ok_o,
  output logic       blank_line_seen_o,
  output logic [4:0] header_count_o
);

  result_t    res [2];
  logic [1:0] res_cnt;
  result_t    head;
  logic       accept;

  assign accept = push && !full;

  tmhp_front #(
    .ROUTE_BYTES  (ROUTE_BYTES),
    .BODY_BYTES   (BODY_BYTES),
    .NAME_BYTES   (NAME_BYTES),
    .VALUE_BYTES  (VALUE_BYTES),
    .HEADER_SLOTS (HEADER_SLOTS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (accept),
    .in_byte_i        (in_byte_i),
    .end_of_message_i (end_of_message_i),
    .res_o            (res),
    .res_cnt_o        (res_cnt)
  );

  tmhp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_cnt_i  (res_cnt),
    .wr_data_i (res),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (empty),
    .full_o    (full)
  );

  assign kind_o            = head.kind;
  assign out_byte_o        = head.out_byte;
  assign header_slot_o     = head.header_slot;
  assign field_offset_o    = head.field_offset;
  assign run_last_o        = head.run_last;
  assign message_end_o     = head.message_end;
  assign prefix_ok_o       = head.prefix_ok;
  assign blank_line_seen_o = head.blank_line_seen;
  assign header_count_o    = head.header_count;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tmhp_pkg::*;

  localparam int ROUTE_MAX   = ROUTE_BYTES_DEF - 1;
  localparam int BODY_MAX    = BODY_BYTES_DEF - 1;
  localparam int NAME_MAX    = NAME_BYTES_DEF - 1;
  localparam int VALUE_MAX   = VALUE_BYTES_DEF - 1;
  // header line bytes at or past this position are dropped
  localparam int LINE_KEEP   = NAME_BYTES_DEF + VALUE_BYTES_DEF + 3;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [3:0] {
    PS_P0, PS_P1, PS_P2, PS_ROUTE, PS_ROUTE_REST, PS_LINE_START, PS_HEADER,
    PS_SKIP, PS_BODY, PS_END_NOBODY, PS_END_BODY, PS_BAD
  } parse_phase_e;

  typedef struct {
    logic [7:0] ch;
    bit         eom;
    bit         typed;
    kind_e      kind;
    logic [7:0] ob;
    logic [8:0] off;
    bit         me;
    bit         pok;
    bit         blank;
    logic [4:0] cnt;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       end_of_message_i;
  logic       empty;
  logic       pop;
  logic [2:0] kind_o;
  logic [7:0] out_byte_o;
  logic [3:0] header_slot_o;
  logic [8:0] field_offset_o;
  logic       run_last_o;
  logic       message_end_o;
  logic       prefix_ok_o;
  logic       blank_line_seen_o;
  logic [4:0] header_count_o;

  // parser state mirror
  parse_phase_e ph;
  int           line_pos;
  int           name_len;
  int           value_len;
  int           route_len;
  int           body_len;
  int           hdr_cnt;
  bit           colon_pend;
  bit           sep_seen;

  result_t    step_tags[$];
  result_t    expected_tags[$];
  logic [7:0] msg_bytes[$];

  int errors;
  int phase_items;
  int gap_pct;
  int stall_pct;
  bit hold_req;

  // directed stimulus; typed rows carry their expected single result
  dir_row_t dir_rows [25] = '{
    '{CH_P,     0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_NUL,   1, 1, KIND_DROP,  8'h00, 9'd0, 1, 0, 0, 5'd0},
    '{CH_P,     0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_T,     0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_SP,    0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{8'hFF,    0, 1, KIND_ROUTE, 8'hFF, 9'd0, 0, 0, 0, 5'd0},
    '{CH_SP,    0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{"z",      0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_LF,    0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{"A",      0, 1, KIND_NAME,  "A",   9'd0, 0, 0, 0, 5'd0},
    '{CH_COLON, 0, 0, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{"B",      0, 0, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_COLON, 0, 0, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_SP,    0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{"v",      0, 1, KIND_VALUE, "v",   9'd0, 0, 0, 0, 5'd0},
    '{CH_LF,    0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_LF,    0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{8'hFF,    0, 1, KIND_BODY,  8'hFF, 9'd0, 0, 0, 0, 5'd0},
    '{CH_NUL,   0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{"q",      1, 1, KIND_DROP,  8'h00, 9'd0, 1, 1, 1, 5'd1},
    '{CH_P,     0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_T,     0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_SP,    0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_LF,    0, 1, KIND_DROP,  8'h00, 9'd0, 0, 0, 0, 5'd0},
    '{CH_COLON, 1, 1, KIND_NAME,  CH_COLON, 9'd0, 1, 1, 0, 5'd1}
  };

  int gap_tab [3]   = '{48, 0, 20};
  int stall_tab [3] = '{0, 48, 20};

  text_message_header_parser_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .in_byte_i        (in_byte_i),
    .end_of_message_i (end_of_message_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .header_slot_o    (header_slot_o),
    .field_offset_o   (field_offset_o),
    .run_last_o       (run_last_o),
    .message_end_o    (message_end_o),
    .prefix_ok_o      (prefix_ok_o),
    .blank_line_seen_o(blank_line_seen_o),
    .header_count_o   (header_count_o)
  );

  function automatic void add_tag(kind_e k, logic [7:0] ch, int slot, int off);
    result_t r;
    if (step_tags.size() >= 2) return;
    r = '0;
    r.kind = k;
    if (k != KIND_DROP) begin
      r.out_byte     = ch;
      r.field_offset = 9'(off);
    end
    if (k == KIND_NAME || k == KIND_VALUE) r.header_slot = 4'(slot);
    step_tags.push_back(r);
  endfunction

  function automatic void drop_tag();
    add_tag(KIND_DROP, 8'h00, 0, 0);
  endfunction

  function automatic int cur_slot();
    return (hdr_cnt != 0) ? hdr_cnt - 1 : 0;
  endfunction

  function automatic void tag_name_char(logic [7:0] ch);
    if (name_len < NAME_MAX) begin
      add_tag(KIND_NAME, ch, cur_slot(), name_len);
      name_len++;
    end else begin
      drop_tag();
    end
  endfunction

  function automatic void flush_held_colon();
    if (colon_pend) begin
      colon_pend = 1'b0;
      tag_name_char(CH_COLON);
    end
  endfunction

  function automatic void start_line();
    line_pos   = 0;
    name_len   = 0;
    value_len  = 0;
    colon_pend = 1'b0;
    sep_seen   = 1'b0;
  endfunction

  function automatic void reset_parser();
    ph        = PS_P0;
    route_len = 0;
    body_len  = 0;
    hdr_cnt   = 0;
    start_line();
  endfunction

  function automatic void header_char(logic [7:0] ch, bit eom);
    int pos;
    pos = line_pos;
    if (ch == CH_LF) begin
      flush_held_colon();
      drop_tag();
      ph = PS_LINE_START;
      start_line();
      return;
    end
    if (ch == CH_NUL) begin
      flush_held_colon();
      drop_tag();
      ph = PS_END_NOBODY;
      return;
    end
    if (sep_seen) begin
      if (pos < LINE_KEEP && value_len < VALUE_MAX) begin
        add_tag(KIND_VALUE, ch, cur_slot(), value_len);
        value_len++;
      end else begin
        drop_tag();
      end
    end else if (colon_pend && ch == CH_SP) begin
      colon_pend = 1'b0;
      sep_seen   = 1'b1;
      drop_tag();
    end else begin
      flush_held_colon();
      // a colon is held back unless it is the last byte or sits at the cut
      if (ch == CH_COLON && pos + 1 < LINE_KEEP && !eom) colon_pend = 1'b1;
      else if (pos < LINE_KEEP) tag_name_char(ch);
      else drop_tag();
    end
    line_pos = (pos < LINE_KEEP) ? pos + 1 : LINE_KEEP;
  endfunction

  function automatic void parse_char(logic [7:0] ch, bit eom);
    logic [7:0] want;
    case (ph)
      PS_P0, PS_P1, PS_P2: begin
        want = (ph == PS_P0) ? CH_P : (ph == PS_P1) ? CH_T : CH_SP;
        ph = (ch == want) ? parse_phase_e'(ph + 1) : PS_BAD;
        drop_tag();
      end
      PS_ROUTE: begin
        if (ch == CH_SP) begin
          ph = PS_ROUTE_REST;
          drop_tag();
        end else if (ch == CH_LF) begin
          ph = PS_LINE_START;
          start_line();
          drop_tag();
        end else if (ch == CH_NUL) begin
          ph = PS_END_NOBODY;
          drop_tag();
        end else if (route_len < ROUTE_MAX) begin
          add_tag(KIND_ROUTE, ch, 0, route_len);
          route_len++;
        end else begin
          drop_tag();
        end
      end
      PS_ROUTE_REST, PS_SKIP: begin
        if (ch == CH_LF) begin
          ph = PS_LINE_START;
          start_line();
        end else if (ch == CH_NUL) begin
          ph = PS_END_NOBODY;
        end
        drop_tag();
      end
      PS_LINE_START: begin
        if (ch == CH_LF) begin
          ph = PS_BODY;
          drop_tag();
        end else if (ch == CH_NUL) begin
          ph = PS_END_NOBODY;
          drop_tag();
        end else if (hdr_cnt < HEADER_SLOTS_DEF) begin
          hdr_cnt++;
          ph = PS_HEADER;
          start_line();
          header_char(ch, eom);
        end else begin
          ph = PS_SKIP;
          drop_tag();
        end
      end
      PS_HEADER: header_char(ch, eom);
      PS_BODY: begin
        if (ch == CH_NUL) begin
          ph = PS_END_BODY;
          drop_tag();
        end else if (body_len < BODY_MAX) begin
          add_tag(KIND_BODY, ch, 0, body_len);
          body_len++;
        end else begin
          drop_tag();
        end
      end
      default: drop_tag();
    endcase
  endfunction

  // fills step_tags with the results one input byte causes
  function automatic void predict_tags(logic [7:0] ch, bit eom);
    result_t r;
    step_tags.delete();
    parse_char(ch, eom);
    if (step_tags.size() != 0) begin
      r = step_tags.pop_back();
      r.run_last = 1'b1;
      if (eom) begin
        r.message_end     = 1'b1;
        r.prefix_ok       = !(ph inside {PS_P0, PS_P1, PS_P2, PS_BAD});
        r.blank_line_seen = (ph == PS_BODY || ph == PS_END_BODY);
        r.header_count    = 5'(hdr_cnt);
      end
      step_tags.push_back(r);
    end
    if (eom) reset_parser();
  endfunction

  function automatic string tag_text(result_t t);
    return $sformatf("kind=%0d byte=%02h slot=%0d off=%0d last=%b end=%b pfx=%b blank=%b hdrs=%0d",
                     t.kind, t.out_byte, t.header_slot, t.field_offset, t.run_last,
                     t.message_end, t.prefix_ok, t.blank_line_seen, t.header_count);
  endfunction

  function automatic int pick_len(int lo, int hi, int big_lo, int big_hi);
    if ($urandom_range(99) < 3) return $urandom_range(big_hi, big_lo);
    return $urandom_range(hi, lo);
  endfunction

  function automatic void add_text(int n, int colon_pct, int space_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < colon_pct) msg_bytes.push_back(CH_COLON);
      else if (r < colon_pct + space_pct) msg_bytes.push_back(CH_SP);
      else if (r < 95) msg_bytes.push_back(8'($urandom_range(8'h7E, 8'h21)));
      else msg_bytes.push_back(8'($urandom_range(255, 1)));
    end
  endfunction

  task automatic send_byte(logic [7:0] ch, bit eom, bit typed, result_t want);
    push             <= 1'b1;
    in_byte_i        <= ch;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_tags(ch, eom);
    if (typed) expected_tags.push_back(want);
    else foreach (step_tags[i]) expected_tags.push_back(step_tags[i]);
    phase_items++;
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // mostly well-formed messages with random content; big forces every limit
  task automatic send_message(bit big);
    int n;
    int nh;
    msg_bytes.delete();
    if (!big && $urandom_range(99) < 8) begin
      n = $urandom_range(12, 1);
      repeat (n) msg_bytes.push_back(8'($urandom_range(255, 0)));
    end else begin
      msg_bytes.push_back(CH_P);
      msg_bytes.push_back(CH_T);
      msg_bytes.push_back(CH_SP);
      if (!big && $urandom_range(99) < 5)
        msg_bytes[$urandom_range(2, 0)] = 8'($urandom_range(255, 0));
      add_text(big ? 130 : pick_len(0, 8, 120, 130), 0, 0);
      if ($urandom_range(99) < 30) begin
        msg_bytes.push_back(CH_SP);
        add_text($urandom_range(6, 0), 10, 20);
      end
      msg_bytes.push_back(CH_LF);
      nh = big ? HEADER_SLOTS_DEF + 1 : pick_len(0, 4, 15, 18);
      for (int h = 0; h < nh; h++) begin
        if (big) begin
          add_text((h == 0) ? 66 : (h == 1) ? 2 : 1, 0, 0);
          if (h < 2) begin
            msg_bytes.push_back(CH_COLON);
            msg_bytes.push_back(CH_SP);
            add_text((h == 0) ? 2 : 193, 5, 5);
          end
        end else begin
          add_text(pick_len(0, 6, 60, 66), 8, 6);
          if ($urandom_range(99) < 80) begin
            msg_bytes.push_back(CH_COLON);
            msg_bytes.push_back(CH_SP);
            n = $urandom_range(99);
            add_text((n < 3) ? $urandom_range(131, 124) :
                     (n < 5) ? $urandom_range(196, 188) : $urandom_range(8, 0), 8, 10);
          end
        end
        msg_bytes.push_back(CH_LF);
      end
      if (big || $urandom_range(99) < 85) begin
        msg_bytes.push_back(CH_LF);
        add_text(big ? 513 : pick_len(0, 12, 505, 515), 5, 5);
      end
    end
    if (!big && $urandom_range(99) < 4)
      msg_bytes[$urandom_range(msg_bytes.size() - 1, 0)] = CH_NUL;
    if (!big && $urandom_range(99) < 8) begin
      n = $urandom_range(msg_bytes.size(), 1);
      while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
    end
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_tags
    result_t got;
    result_t want;
    if (rst_ni && pop && !empty) begin
      got.kind            = kind_e'(kind_o);
      got.out_byte        = out_byte_o;
      got.header_slot     = header_slot_o;
      got.field_offset    = field_offset_o;
      got.run_last        = run_last_o;
      got.message_end     = message_end_o;
      got.prefix_ok       = prefix_ok_o;
      got.blank_line_seen = blank_line_seen_o;
      got.header_count    = header_count_o;
      if (expected_tags.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected transaction: %s", $realtime, tag_text(got));
      end else begin
        want = expected_tags.pop_front();
        if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
            got.header_slot !== want.header_slot ||
            got.field_offset !== want.field_offset || got.run_last !== want.run_last ||
            got.message_end !== want.message_end || got.prefix_ok !== want.prefix_ok ||
            got.blank_line_seen !== want.blank_line_seen ||
            got.header_count !== want.header_count) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: mismatch", $realtime);
            $display("  expected %s", tag_text(want));
            $display("  actual   %s", tag_text(got));
          end
        end
      end
    end
  end

  initial begin : stimulus
    result_t want;
    rst_ni           = 1'b0;
    push             = 1'b0;
    in_byte_i        = 8'h00;
    end_of_message_i = 1'b0;
    errors           = 0;
    phase_items      = 0;
    gap_pct          = 0;
    stall_pct        = 0;
    hold_req         = 1'b0;
    reset_parser();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      want                 = '0;
      want.kind            = dir_rows[i].kind;
      want.out_byte        = dir_rows[i].ob;
      want.field_offset    = dir_rows[i].off;
      want.run_last        = 1'b1;
      want.message_end     = dir_rows[i].me;
      want.prefix_ok       = dir_rows[i].pok;
      want.blank_line_seen = dir_rows[i].blank;
      want.header_count    = dir_rows[i].cnt;
      send_byte(dir_rows[i].ch, dir_rows[i].eom, dir_rows[i].typed, want);
    end

    // sender streams the big message while the receiver holds off
    phase_items = 0;
    hold_req    = 1'b1;
    send_message(1'b1);
    while (phase_items < 1050) send_message(1'b0);

    for (int p = 0; p < 3; p++) begin
      gap_pct     = gap_tab[p];
      stall_pct   = stall_tab[p];
      phase_items = 0;
      while (phase_items < 160) send_message(1'b0);
    end

    push <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hdl/tmhp_pkg.sv
hdl/tmhp_front.sv
hdl/tmhp_queue.sv
hdl/text_message_header_parser_unit.sv
tb/tb.sv
